// ===== sv/size_class_pool_allocator_top_assert.svh =====
// Assertion macros for the size class pool allocator.
`ifndef SIZE_CLASS_POOL_ALLOCATOR_TOP_ASSERT_SVH
`define SIZE_CLASS_POOL_ALLOCATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define SCPA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scpa assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define SCPA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scpa assertion failed");
`else
`define SCPA_ASSERT_SAME(lbl, ante, cons)
`define SCPA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== sv/scpa_pkg.sv =====
// Shared types and constants of the size class pool allocator.
package scpa_pkg;

  localparam int GRAN_BYTES = 8;
  localparam int GRAN_SHIFT = 3;
  localparam int SIZE_W     = 32;
  localparam int ADDR_W     = 18;
  localparam int LINK_AW    = 15;
  localparam int LINK_DW    = 16;

  localparam logic [LINK_DW-1:0] NULL_LINK = 16'hFFFF;

  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  localparam logic [1:0] STAT_DONE    = 2'd0;
  localparam logic [1:0] STAT_ZERO    = 2'd1;
  localparam logic [1:0] STAT_EXT     = 2'd2;
  localparam logic [1:0] STAT_EXHAUST = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_LINK,
    ST_CARVE,
    ST_FIN
  } st_t;

  typedef struct packed {
    logic               we;
    logic [LINK_AW-1:0] waddr;
    logic [LINK_DW-1:0] wdata;
    logic               re;
    logic [LINK_AW-1:0] raddr;
  } link_port_t;

endpackage

// ===== sv/scpa_link_mem.sv =====
// Link memory: next unit index for every unit, one write and one registered read port.
module scpa_link_mem
  import scpa_pkg::*;
(
  input  logic               clk,
  input  link_port_t         port,
  output logic [LINK_DW-1:0] rd_data
);

  logic [LINK_DW-1:0] mem [2**LINK_AW];
  logic [LINK_DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (port.we) begin
      mem[port.waddr] <= port.wdata;
    end
    if (port.re) begin
      rd_data_r <= mem[port.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/size_class_pool_allocator_top.sv =====
// Segregated free-list pool allocator: one result per item, from head and link memories.
// Size zero or oversize goes straight to the result; a release pushes, a pop reads a link,
// a fresh carve fills a block (one link write a cycle, up to BLOCK_BYTES/8 writes).
// One item in flight; the next is taken once the result sits in the output register.
// Reset (synchronous, rst_n low) empties every class list and returns all blocks to the
// pool; link memory contents are left as they are and need no clearing pass.
module size_class_pool_allocator_top
  import scpa_pkg::*;
#(
  parameter int CLASS_COUNT = 16,
  parameter int BLOCK_BYTES = 4096,
  parameter int BLOCK_COUNT = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_mode,
  input  logic [SIZE_W-1:0] in_req_size,
  input  logic [ADDR_W-1:0] in_release_addr,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ADDR_W-1:0] out_unit_addr,
  output logic [1:0]        out_status
);

`include "size_class_pool_allocator_top_assert.svh"

  localparam int CLS_W     = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
  localparam int BLK_UNITS = BLOCK_BYTES / GRAN_BYTES;
  localparam int SUM_W     = $clog2(BLK_UNITS + 2 * CLASS_COUNT + 1);
  localparam int BU_W      = $clog2(BLOCK_COUNT + 1);

  st_t state_r, state_nxt;

  logic                 mode_r,      mode_nxt;
  logic [CLS_W-1:0]     cls_r,       cls_nxt;
  logic [LINK_AW-1:0]   idx_r,       idx_nxt;
  logic [LINK_AW-1:0]   hptr_r,      hptr_nxt;
  logic [SUM_W-1:0]     off_r,       off_nxt;
  logic [BU_W-1:0]      blocks_r,    blocks_nxt;
  logic [ADDR_W-1:0]    base_byte_r, base_byte_nxt;
  logic [CLASS_COUNT-1:0] head_vld_r, head_vld_nxt;
  logic [ADDR_W-1:0]    res_addr_r,  res_addr_nxt;
  logic [1:0]           res_stat_r,  res_stat_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]    out_addr_r,  out_addr_nxt;
  logic [1:0]           out_stat_r,  out_stat_nxt;

  logic [LINK_DW-1:0] head_mem [CLASS_COUNT];
  logic [LINK_DW-1:0] head_rd_r;
  logic               head_re;
  logic               head_we;
  logic [LINK_DW-1:0] head_wd;

  link_port_t         link_port;
  logic [LINK_DW-1:0] link_rd;

  logic              acc;
  logic              size_zero;
  logic              size_big;
  logic [SIZE_W-1:0] size_m1;
  logic [CLS_W-1:0]  cls_in;
  logic [LINK_DW-1:0] cur_head;
  logic              head_empty;
  logic              pool_full;
  logic [SUM_W-1:0]  step;
  logic              carve_last;
  logic              fin_go;
  logic [LINK_AW-1:0] base_idx;
  logic [LINK_AW-1:0] carve_idx;

  // Input decode
  assign acc       = in_valid && !in_stall;
  assign size_zero = (in_req_size == '0);
  assign size_big  = (in_req_size > SIZE_W'(CLASS_COUNT * GRAN_BYTES));
  assign size_m1   = in_req_size - SIZE_W'(1);
  assign cls_in    = size_m1[GRAN_SHIFT +: CLS_W];

  // Working values
  assign cur_head   = head_vld_r[cls_r] ? head_rd_r : NULL_LINK;
  assign head_empty = (cur_head == NULL_LINK);
  assign pool_full  = (blocks_r >= BU_W'(BLOCK_COUNT));
  assign step       = SUM_W'(cls_r) + SUM_W'(1);
  // The unit at this offset is the last of the block when no further whole unit fits
  assign carve_last = ((off_r + step + step) > SUM_W'(BLK_UNITS));
  assign base_idx   = base_byte_r[ADDR_W-1:GRAN_SHIFT];
  assign carve_idx  = base_idx + LINK_AW'(off_r);
  assign fin_go     = !out_valid_r || !out_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          state_nxt = (size_zero || size_big) ? ST_FIN : ST_HEAD;
        end
      end
      ST_HEAD: begin
        if (mode_r == MODE_RELEASE) begin
          state_nxt = ST_FIN;
        end else if (!head_empty) begin
          state_nxt = ST_LINK;
        end else if (pool_full) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_CARVE;
        end
      end
      ST_LINK: state_nxt = ST_FIN;
      ST_CARVE: begin
        if (carve_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    mode_nxt      = mode_r;
    cls_nxt       = cls_r;
    idx_nxt       = idx_r;
    hptr_nxt      = hptr_r;
    off_nxt       = off_r;
    blocks_nxt    = blocks_r;
    base_byte_nxt = base_byte_r;
    head_vld_nxt  = head_vld_r;
    res_addr_nxt  = res_addr_r;
    res_stat_nxt  = res_stat_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_addr_nxt  = out_addr_r;
    out_stat_nxt  = out_stat_r;
    head_re       = 1'b0;
    head_we       = 1'b0;
    head_wd       = NULL_LINK;
    link_port     = '0;
    in_stall      = (state_r != ST_IDLE);

    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          mode_nxt     = in_mode;
          cls_nxt      = cls_in;
          idx_nxt      = in_release_addr[ADDR_W-1:GRAN_SHIFT];
          res_addr_nxt = '0;
          if (size_zero) begin
            res_stat_nxt = STAT_ZERO;
          end else if (size_big) begin
            res_stat_nxt = STAT_EXT;
          end else begin
            head_re = 1'b1;
          end
        end
      end
      ST_HEAD: begin
        res_addr_nxt = '0;
        res_stat_nxt = STAT_DONE;
        off_nxt      = '0;
        if (mode_r == MODE_RELEASE) begin
          // Push: old head becomes the released unit's successor
          link_port.we    = 1'b1;
          link_port.waddr = idx_r;
          link_port.wdata = cur_head;
          head_we         = 1'b1;
          head_wd         = LINK_DW'(idx_r);
        end else if (!head_empty) begin
          link_port.re    = 1'b1;
          link_port.raddr = cur_head[LINK_AW-1:0];
          hptr_nxt        = cur_head[LINK_AW-1:0];
        end else if (pool_full) begin
          res_stat_nxt = STAT_EXHAUST;
        end
      end
      ST_LINK: begin
        head_we      = 1'b1;
        head_wd      = link_rd;
        res_addr_nxt = {hptr_r, GRAN_SHIFT'(0)};
      end
      ST_CARVE: begin
        link_port.we    = 1'b1;
        link_port.waddr = carve_idx;
        link_port.wdata = carve_last ? NULL_LINK
                                     : LINK_DW'(carve_idx + LINK_AW'(step));
        off_nxt = off_r + step;
        if (carve_last) begin
          // First unit goes out, second (if any) heads the list
          head_we = 1'b1;
          head_wd = ((step + step) > SUM_W'(BLK_UNITS)) ? NULL_LINK
                  : LINK_DW'(base_idx + LINK_AW'(step));
          blocks_nxt    = blocks_r + BU_W'(1);
          base_byte_nxt = base_byte_r + ADDR_W'(BLOCK_BYTES);
          res_addr_nxt  = {base_idx, GRAN_SHIFT'(0)};
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = res_addr_r;
          out_stat_nxt  = res_stat_r;
        end
      end
      default: ;
    endcase

    if (head_we) begin
      head_vld_nxt[cls_r] = 1'b1;
    end
  end

  // Head memory
  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[cls_r] <= head_wd;
    end
    if (head_re) begin
      head_rd_r <= head_mem[cls_in];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      blocks_r    <= '0;
      base_byte_r <= '0;
      head_vld_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      blocks_r    <= blocks_nxt;
      base_byte_r <= base_byte_nxt;
      head_vld_r  <= head_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    cls_r      <= cls_nxt;
    idx_r      <= idx_nxt;
    hptr_r     <= hptr_nxt;
    off_r      <= off_nxt;
    res_addr_r <= res_addr_nxt;
    res_stat_r <= res_stat_nxt;
    out_addr_r <= out_addr_nxt;
    out_stat_r <= out_stat_nxt;
  end

  scpa_link_mem u_link_mem (
    .clk     (clk),
    .port    (link_port),
    .rd_data (link_rd)
  );

  assign out_valid     = out_valid_r;
  assign out_unit_addr = out_addr_r;
  assign out_status    = out_stat_r;

  `SCPA_ASSERT_SAME(a_carve_in_block, state_r == ST_CARVE, off_r < SUM_W'(BLK_UNITS))
  `SCPA_ASSERT_SAME(a_pool_bound, 1'b1, blocks_r <= BU_W'(BLOCK_COUNT))
  `SCPA_ASSERT_NEXT(a_fin_loads_out, state_r == ST_FIN && fin_go, out_valid_r && state_r == ST_IDLE)

endmodule
